/* rtl/natural_log_atanh_series_macros.svh */
// ============================================================================
// Natural log series assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while i_rst_n is low.
// ============================================================================
`ifndef NATURAL_LOG_ATANH_SERIES_MACROS_SVH
`define NATURAL_LOG_ATANH_SERIES_MACROS_SVH

// same-cycle implication
`define NLA_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NLA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/nla_pkg.sv */
// ============================================================================
// Natural log series package
// Fixed widths, datapath operation codes and controller/datapath structs.
// ============================================================================
package nla_pkg;

    localparam int X_W    = 32;
    localparam int TC_W   = 8;
    localparam int K_W    = TC_W + 1;
    localparam int RES_W  = 32;
    localparam int DEN_W  = X_W + 1;
    localparam int REM_W  = DEN_W + 1;

    localparam logic [X_W-1:0]  ONE_Q16        = 32'h0001_0000;
    localparam logic [TC_W-1:0] TERM_COUNT_RST = 8'd16;

    typedef logic [3:0] t_op;

    localparam t_op OP_NONE      = 4'd0;
    localparam t_op OP_LOAD      = 4'd1;
    localparam t_op OP_DIV_STEP  = 4'd2;
    localparam t_op OP_V_SET     = 4'd3;
    localparam t_op OP_MUL_STEP  = 4'd4;
    localparam t_op OP_V2_SET    = 4'd5;
    localparam t_op OP_MUL_INIT  = 4'd6;
    localparam t_op OP_SCALE     = 4'd7;
    localparam t_op OP_ACC       = 4'd8;
    localparam t_op OP_OUT       = 4'd9;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic dom;
        logic more;
    } t_stat;

endpackage

/* rtl/natural_log_atanh_series.sv */
// ============================================================================
// Natural logarithm by inverse hyperbolic tangent series
// Computes ln(x) of an unsigned Q16.16 request as 2*atanh((x-1)/(x+1)).
// ============================================================================
// Usage:
//   Input channel i_in_valid/o_in_ready carries i_x_value (unsigned Q16.16).
//   Output channel o_out_valid/i_out_ready carries o_log_result (signed, with
//   RESULT_FRAC_BITS fraction bits) and o_domain_error.
//   Config channel i_cfg_valid/o_cfg_ready writes i_cfg_term_count, the number
//   of series terms summed; o_cfg_ready is always high. Write only while idle.
//   One request is worked at a time. The series stops early on a zero term,
//   and a zero argument or zero term count goes straight to the result.
//   Each term costs one shift-add multiply and one restoring divide in the
//   shared datapath.
//   The result sits in an output register: a new request is accepted while
//   the previous result waits; if the receiver stalls, the next result holds
//   in the final state until the register frees.
//   Reset clears the controller, drops any pending result and sets the term
//   count to 16.
// ============================================================================
module natural_log_atanh_series #(
    parameter int RESULT_FRAC_BITS   = 24,
    parameter int INTERNAL_FRAC_BITS = 30
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [nla_pkg::X_W-1:0]          i_x_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [nla_pkg::RES_W-1:0] o_log_result,
    output logic                             o_domain_error,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nla_pkg::TC_W-1:0]         i_cfg_term_count
);

    logic [nla_pkg::TC_W-1:0] r_term_count;
    nla_pkg::t_cmd            w_cmd;
    nla_pkg::t_stat           w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count <= nla_pkg::TERM_COUNT_RST;
        end else if (i_cfg_valid) begin
            r_term_count <= i_cfg_term_count;
        end
    end

    assign o_cfg_ready = 1'b1;

    nla_ctrl #(
        .INTERNAL_FRAC_BITS (INTERNAL_FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    nla_dp #(
        .RESULT_FRAC_BITS   (RESULT_FRAC_BITS),
        .INTERNAL_FRAC_BITS (INTERNAL_FRAC_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .i_x_value      (i_x_value),
        .i_term_count   (r_term_count),
        .o_stat         (w_stat),
        .o_log_result   (o_log_result),
        .o_domain_error (o_domain_error)
    );

endmodule

/* rtl/nla_dp.sv */
// ============================================================================
// Natural log series datapath
// Shared shift-add multiplier and restoring divider, term accumulator and
// output rescale with saturation.
// ============================================================================
module nla_dp #(
    parameter int RESULT_FRAC_BITS   = 24,
    parameter int INTERNAL_FRAC_BITS = 30
) (
    input  logic                         i_clk,
    input  nla_pkg::t_cmd                i_cmd,
    input  logic [nla_pkg::X_W-1:0]      i_x_value,
    input  logic [nla_pkg::TC_W-1:0]     i_term_count,
    output nla_pkg::t_stat               o_stat,
    output logic signed [nla_pkg::RES_W-1:0] o_log_result,
    output logic                         o_domain_error
);

    localparam int F     = INTERNAL_FRAC_BITS;
    localparam int SUM_W = F + nla_pkg::TC_W;
    localparam int P_W   = F + nla_pkg::K_W;
    localparam int SH_L  = (RESULT_FRAC_BITS > F) ? (RESULT_FRAC_BITS - F) : 0;
    localparam int SH_R  = (F >= RESULT_FRAC_BITS) ? (F - RESULT_FRAC_BITS) : 0;
    localparam int MAG_W = SUM_W + 1 + SH_L;

    localparam logic [MAG_W-1:0] MAG_NEG_MAX = MAG_W'(64'h0000_0000_8000_0000);
    localparam logic [MAG_W-1:0] MAG_POS_MAX = MAG_W'(64'h0000_0000_7FFF_FFFF);

    logic [nla_pkg::REM_W-1:0]  r_rem;
    logic [nla_pkg::DEN_W-1:0]  r_div;
    logic [F-1:0]               r_sh;
    logic [F:0]                 r_hi;
    logic [F-1:0]               r_ma;
    logic [F-1:0]               r_v2;
    logic [F-1:0]               r_t;
    logic [SUM_W-1:0]           r_sum;
    logic [nla_pkg::TC_W-1:0]   r_i;
    logic [nla_pkg::TC_W-1:0]   r_n;
    logic                       r_neg;
    logic                       r_dom;
    logic [nla_pkg::RES_W-1:0]  r_log;
    logic                       r_dom_out;

    logic                       w_x_neg;
    logic [nla_pkg::X_W-1:0]    w_num;
    logic [nla_pkg::REM_W-1:0]  w_shift;
    logic                       w_ge;
    logic [F:0]                 w_add;
    logic [nla_pkg::K_W-1:0]    w_k_mul;
    logic [nla_pkg::K_W-1:0]    w_k_div;
    logic [P_W-1:0]             w_prod;
    logic [MAG_W-1:0]           w_mag;
    logic [nla_pkg::RES_W-1:0]  w_res;

    assign w_x_neg = i_x_value < nla_pkg::ONE_Q16;
    assign w_num   = w_x_neg ? (nla_pkg::ONE_Q16 - i_x_value) : (i_x_value - nla_pkg::ONE_Q16);

    assign w_shift = {r_rem[nla_pkg::REM_W-2:0], r_sh[F-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};

    assign w_add   = r_hi + (r_sh[0] ? {1'b0, r_ma} : '0);

    assign w_k_mul = {r_i, 1'b0} - nla_pkg::K_W'(1);
    assign w_k_div = {r_i, 1'b0} + nla_pkg::K_W'(1);
    assign w_prod  = P_W'(r_hi[F-1:0]) * P_W'(w_k_mul);

    always_comb begin
        w_mag = (MAG_W'({r_sum, 1'b0}) << SH_L) >> SH_R;
        if (r_neg) begin
            w_res = (w_mag > MAG_NEG_MAX) ? 32'h8000_0000 : (32'd0 - w_mag[nla_pkg::RES_W-1:0]);
        end else begin
            w_res = (w_mag > MAG_POS_MAX) ? 32'h7FFF_FFFF : w_mag[nla_pkg::RES_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            nla_pkg::OP_LOAD: begin
                r_neg <= w_x_neg;
                r_rem <= nla_pkg::REM_W'(w_num);
                r_div <= nla_pkg::DEN_W'(i_x_value) + nla_pkg::DEN_W'(nla_pkg::ONE_Q16);
                r_sh  <= '0;
                r_dom <= (i_x_value == '0) || (i_term_count == '0);
                r_n   <= i_term_count;
                r_i   <= nla_pkg::TC_W'(1);
            end
            nla_pkg::OP_DIV_STEP: begin
                r_rem <= w_ge ? (w_shift - nla_pkg::REM_W'(r_div)) : w_shift;
                r_sh  <= {r_sh[F-2:0], w_ge};
            end
            nla_pkg::OP_V_SET: begin
                r_t   <= r_sh;
                r_sum <= SUM_W'(r_sh);
                r_ma  <= r_sh;
                r_hi  <= '0;
            end
            nla_pkg::OP_MUL_STEP: begin
                r_hi <= {1'b0, w_add[F:1]};
                r_sh <= r_sh >> 1;
            end
            nla_pkg::OP_V2_SET: begin
                r_v2 <= r_hi[F-1:0];
            end
            nla_pkg::OP_MUL_INIT: begin
                r_ma <= r_t;
                r_sh <= r_v2;
                r_hi <= '0;
            end
            nla_pkg::OP_SCALE: begin
                r_rem <= nla_pkg::REM_W'(w_prod[P_W-1:F]);
                r_sh  <= w_prod[F-1:0];
                r_div <= nla_pkg::DEN_W'(w_k_div);
            end
            nla_pkg::OP_ACC: begin
                r_t   <= r_sh;
                r_sum <= r_sum + SUM_W'(r_sh);
                r_i   <= r_i + nla_pkg::TC_W'(1);
            end
            nla_pkg::OP_OUT: begin
                r_log     <= r_dom ? '0 : w_res;
                r_dom_out <= r_dom;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.dom     = r_dom;
    assign o_stat.more    = (r_i < r_n) && (r_t != '0);
    assign o_log_result   = r_log;
    assign o_domain_error = r_dom_out;

endmodule

/* rtl/nla_ctrl.sv */
// ============================================================================
// Natural log series controller
// Sequences division, squaring and the per-term multiply/scale/divide loop,
// and owns the input and result handshakes.
// ============================================================================
`include "natural_log_atanh_series_macros.svh"

module nla_ctrl #(
    parameter int INTERNAL_FRAC_BITS = 30
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  nla_pkg::t_stat i_stat,
    output nla_pkg::t_cmd  o_cmd
);

    localparam int F     = INTERNAL_FRAC_BITS;
    localparam int CNT_W = $clog2(F);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(F - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_VSET  = 4'd3;
    localparam logic [3:0] S_MULV  = 4'd4;
    localparam logic [3:0] S_V2    = 4'd5;
    localparam logic [3:0] S_LOOP  = 4'd6;
    localparam logic [3:0] S_MULT  = 4'd7;
    localparam logic [3:0] S_SCALE = 4'd8;
    localparam logic [3:0] S_DIVT  = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]       r_state;
    logic [3:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_cnt_last;
    logic             w_out_free;

    assign w_cnt_last = r_cnt == CNT_LAST;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.op   = nla_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = nla_pkg::OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt   = '0;
                n_state = i_stat.dom ? S_FIN : S_DIV;
            end
            S_DIV, S_MULV, S_MULT, S_DIVT: begin
                o_cmd.op = ((r_state == S_DIV) || (r_state == S_DIVT)) ?
                           nla_pkg::OP_DIV_STEP : nla_pkg::OP_MUL_STEP;
                n_cnt    = r_cnt + CNT_W'(1);
                if (w_cnt_last) begin
                    n_cnt = '0;
                    case (r_state)
                        S_DIV:   n_state = S_VSET;
                        S_MULV:  n_state = S_V2;
                        S_MULT:  n_state = S_SCALE;
                        default: n_state = S_ACC;
                    endcase
                end
            end
            S_VSET: begin
                o_cmd.op = nla_pkg::OP_V_SET;
                n_state  = S_MULV;
            end
            S_V2: begin
                o_cmd.op = nla_pkg::OP_V2_SET;
                n_state  = S_LOOP;
            end
            S_LOOP: begin
                if (i_stat.more) begin
                    o_cmd.op = nla_pkg::OP_MUL_INIT;
                    n_state  = S_MULT;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCALE: begin
                o_cmd.op = nla_pkg::OP_SCALE;
                n_state  = S_DIVT;
            end
            S_ACC: begin
                o_cmd.op = nla_pkg::OP_ACC;
                n_state  = S_LOOP;
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.op = nla_pkg::OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (r_state == S_FIN && w_out_free) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    `NLA_ASSERT_NEXT(a_accept_to_check, i_in_valid && o_in_ready, r_state == S_CHECK, "accepted request did not start")
    `NLA_ASSERT_IMPLY(a_cnt_range, r_state != S_IDLE, r_cnt <= CNT_LAST, "step counter out of range")
    `NLA_ASSERT_NEXT(a_fin_publishes, r_state == S_FIN && w_out_free, o_out_valid && r_state == S_IDLE, "finished result not published")

endmodule
